[rtl/core/tlp_pkg.sv]
package tlp_pkg;

  localparam int unsigned OUT_W   = 12;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned LPT_W   = 16;
  localparam int unsigned SLOP_W  = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned TS_W    = 32;
  localparam int unsigned FID_W   = 8;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned NRES    = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned IDX_W   = 2;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd240;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd320;
  localparam logic [LPT_W-1:0]  LPT_RST    = 16'd600;
  localparam logic [SLOP_W-1:0] SLOP_RST   = 8'd10;

  typedef enum logic [2:0] {
    OP_DOWN   = 3'd0,
    OP_MOTION = 3'd1,
    OP_UP     = 3'd2,
    OP_TICK   = 3'd3,
    OP_CANCEL = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_POINTER = 3'd0,
    KIND_PCANCEL = 3'd1,
    KIND_CBEGIN  = 3'd2,
    KIND_CMOVE   = 3'd3,
    KIND_CEND    = 3'd4,
    KIND_CCANCEL = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LPT    = 2'd2,
    CFG_SLOP   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [FID_W-1:0] fid;
    logic [TS_W-1:0]  ts;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             pressed;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    res_t [NRES-1:0]   res;
  } bundle_t;

endpackage

[rtl/core/tlp_if.sv]
interface tlp_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [7:0]        finger_id;
  logic signed [13:0] pos_x;
  logic signed [13:0] pos_y;
  logic [31:0]       timestamp;

  modport source (output valid, operation, finger_id, pos_x, pos_y, timestamp,
                  input ready);
  modport sink   (input valid, operation, finger_id, pos_x, pos_y, timestamp,
                  output ready);
endinterface

interface tlp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [11:0] out_x;
  logic [11:0] out_y;
  logic        pressed;
  logic        last;

  modport source (output valid, event_kind, out_x, out_y, pressed, last,
                  input ready);
  modport sink   (input valid, event_kind, out_x, out_y, pressed, last,
                  output ready);
endinterface

[rtl/core/tlp_clamp.sv]
module tlp_clamp #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic signed [tlp_pkg::POS_W-1:0]  pos_i,
  input  logic        [tlp_pkg::SIZE_W-1:0] size_i,
  output logic        [COORD_WIDTH-1:0]     coord_o
);
  import tlp_pkg::*;

  localparam int unsigned EW = 17;
  localparam logic [EW-1:0] MASK = (EW'(1) << COORD_WIDTH) - EW'(1);

  logic [EW-1:0] hi;
  logic [EW-1:0] lim;
  logic [EW-1:0] val;

  always_comb begin
    hi  = EW'(size_i) - EW'(1);
    lim = (hi > MASK) ? MASK : hi;
    val = EW'(unsigned'(pos_i[POS_W-2:0]));
    if (size_i == '0) begin
      coord_o = '0;
    end else if (pos_i[POS_W-1]) begin
      coord_o = '0;
    end else if (val > lim) begin
      coord_o = COORD_WIDTH'(lim);
    end else begin
      coord_o = COORD_WIDTH'(val);
    end
  end

endmodule

[rtl/core/tlp_core.sv]
module tlp_core #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tlp_pkg::item_t               in_item_i,
  input  logic [COORD_WIDTH-1:0]       in_x_i,
  input  logic [COORD_WIDTH-1:0]       in_y_i,
  input  logic [tlp_pkg::LPT_W-1:0]    lpt_i,
  input  logic [tlp_pkg::SLOP_W-1:0]   slop_i,
  input  logic                         bundle_ready_i,
  output logic                         bundle_valid_o,
  output tlp_pkg::bundle_t             bundle_o
);
  import tlp_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned SQW = 2 * CW + 1;

  // input register
  logic          vld_q;
  item_t         item_q;
  logic [CW-1:0] x_q, y_q;
  logic          commit;

  // touch state
  logic          act_q, act_d;
  logic [FID_W-1:0] fid_q, fid_d;
  logic [CW-1:0] sx_q, sx_d, sy_q, sy_d, cx_q, cx_d, cy_q, cy_d;
  logic [TS_W-1:0] st_q, st_d;
  logic          elig_q, elig_d;
  logic          fired_q, fired_d;

  logic            fire;
  logic            moved;
  logic [TS_W-1:0] elapsed;
  logic            match;
  logic            fired_eff, elig_eff;
  logic            op_emit;
  res_t            op_res;
  logic [CNT_W-1:0] n_fire;
  res_t [NRES-1:0] fire_res;
  logic signed [CW:0] dx, dy;
  logic [CW-1:0]   adx, ady;
  logic [SQW-1:0]  dist2, r2;

  assign commit     = vld_q & bundle_ready_i;
  assign in_ready_o = ~vld_q | commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
      x_q    <= in_x_i;
      y_q    <= in_y_i;
    end
  end

  // slop test: squared distance of the new point from the start point
  always_comb begin
    dx    = $signed({1'b0, x_q}) - $signed({1'b0, sx_q});
    dy    = $signed({1'b0, y_q}) - $signed({1'b0, sy_q});
    adx   = dx[CW] ? CW'(-dx) : CW'(dx);
    ady   = dy[CW] ? CW'(-dy) : CW'(dy);
    dist2 = SQW'(adx * adx) + SQW'(ady * ady);
    r2    = SQW'(slop_i * slop_i);
  end

  always_comb begin
    elapsed = item_q.ts - st_q;
    match   = act_q && (item_q.fid == fid_q);
    moved   = (cx_q != sx_q) || (cy_q != sy_q);
    fire    = (item_q.op != OP_CANCEL) && (item_q.ts != '0) && act_q && elig_q &&
              !fired_q && (elapsed >= TS_W'(lpt_i));
    fired_eff = fired_q | fire;
    elig_eff  = elig_q & ~fire;
    n_fire    = fire ? (moved ? CNT_W'(3) : CNT_W'(2)) : CNT_W'(0);

    fire_res[0] = '{kind: KIND_PCANCEL, x: '0, y: '0, pressed: 1'b0};
    fire_res[1] = '{kind: KIND_CBEGIN, x: OUT_W'(sx_q), y: OUT_W'(sy_q), pressed: 1'b0};
    fire_res[2] = '{kind: KIND_CMOVE, x: OUT_W'(cx_q), y: OUT_W'(cy_q), pressed: 1'b0};
    fire_res[3] = '{kind: KIND_PCANCEL, x: '0, y: '0, pressed: 1'b0};

    act_d   = act_q;
    fid_d   = fid_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    st_d    = st_q;
    elig_d  = elig_eff;
    fired_d = fired_eff;
    op_emit = 1'b0;
    op_res  = '{kind: KIND_POINTER, x: OUT_W'(x_q), y: OUT_W'(y_q), pressed: 1'b0};

    unique case (item_q.op)
      OP_CANCEL: begin
        op_emit = act_q;
        op_res  = '{kind: fired_q ? KIND_CCANCEL : KIND_PCANCEL,
                    x: '0, y: '0, pressed: 1'b0};
        act_d   = 1'b0;
        fid_d   = '0;
        sx_d    = '0;
        sy_d    = '0;
        cx_d    = '0;
        cy_d    = '0;
        st_d    = '0;
        elig_d  = 1'b0;
        fired_d = 1'b0;
      end
      OP_DOWN: begin
        if (!act_q) begin
          op_emit = 1'b1;
          op_res.pressed = 1'b1;
          act_d   = 1'b1;
          fid_d   = item_q.fid;
          sx_d    = x_q;
          sy_d    = y_q;
          cx_d    = x_q;
          cy_d    = y_q;
          st_d    = item_q.ts;
          elig_d  = 1'b1;
          fired_d = 1'b0;
        end
      end
      OP_MOTION: begin
        if (match) begin
          op_emit = 1'b1;
          cx_d    = x_q;
          cy_d    = y_q;
          if (elig_eff && (dist2 > r2)) begin
            elig_d = 1'b0;
          end
          if (fired_eff) begin
            op_res.kind = KIND_CMOVE;
          end else begin
            op_res.pressed = 1'b1;
          end
        end
      end
      OP_UP: begin
        if (match) begin
          op_emit = 1'b1;
          if (fired_eff) begin
            op_res.kind = KIND_CEND;
          end
          act_d   = 1'b0;
          fid_d   = '0;
          sx_d    = '0;
          sy_d    = '0;
          cx_d    = '0;
          cy_d    = '0;
          st_d    = '0;
          elig_d  = 1'b0;
          fired_d = 1'b0;
        end
      end
      default: begin
        // tick and unused codes run the long-press check only
      end
    endcase

    // pack the fire words first, then the word of the event itself
    for (int i = 0; i < NRES; i++) begin
      if (CNT_W'(i) < n_fire) begin
        bundle_o.res[i] = fire_res[i];
      end else begin
        bundle_o.res[i] = op_res;
      end
    end
    bundle_o.cnt   = n_fire + CNT_W'(op_emit);
    bundle_valid_o = commit && (bundle_o.cnt != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      fid_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      st_q    <= '0;
      elig_q  <= 1'b0;
      fired_q <= 1'b0;
    end else if (commit) begin
      act_q   <= act_d;
      fid_q   <= fid_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      st_q    <= st_d;
      elig_q  <= elig_d;
      fired_q <= fired_d;
    end
  end

endmodule

[rtl/core/tlp_drain.sv]
module tlp_drain (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             bundle_valid_i,
  output logic             bundle_ready_o,
  input  tlp_pkg::bundle_t bundle_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output tlp_pkg::res_t    res_o,
  output logic             res_last_o
);
  import tlp_pkg::*;

  res_t [NRES-1:0]  res_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] idx_q;
  logic             take;

  assign res_valid_o    = (cnt_q != '0);
  assign res_o          = res_q[idx_q];
  assign res_last_o     = ({1'b0, idx_q} == (cnt_q - CNT_W'(1)));
  assign take           = res_valid_o & res_ready_i;
  assign bundle_ready_o = ~res_valid_o | (take & res_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (bundle_ready_o && bundle_valid_i) begin
      cnt_q <= bundle_i.cnt;
      idx_q <= '0;
    end else if (take && res_last_o) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (take) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bundle_ready_o && bundle_valid_i) begin
      res_q <= bundle_i.res;
    end
  end

endmodule

[rtl/core/touch_long_press_recognizer.sv]
// Flow: an accepted word enters the input register and is evaluated from there; its
// result words are registered in the result stage and then offered on the output.
// The evaluate stage takes one event per cycle while the result stage can accept its
// bundle; an event makes 0 to 4 result words, sent one per output handshake.
// Reset: rst_ni clears the touch state and restores the default screen, hold time
// and slop settings; no word is pending after reset.
module touch_long_press_recognizer #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tlp_in_if.sink                      in_i,
  tlp_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [tlp_pkg::CFG_W-1:0]   cfg_wdata_i
);
  import tlp_pkg::*;

  // Configuration registers: the user writes only while the block is idle (unchecked).
  logic [SIZE_W-1:0] width_q, height_q;
  logic [LPT_W-1:0]  lpt_q;
  logic [SLOP_W-1:0] slop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      lpt_q    <= LPT_RST;
      slop_q   <= SLOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[SIZE_W-1:0];
        CFG_LPT:    lpt_q    <= cfg_wdata_i[LPT_W-1:0];
        CFG_SLOP:   slop_q   <= cfg_wdata_i[SLOP_W-1:0];
      endcase
    end
  end

  // Clamp the raw position to the screen before it enters the input register.
  logic [COORD_WIDTH-1:0] cx, cy;

  tlp_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_x (
    .pos_i   (in_i.pos_x),
    .size_i  (width_q),
    .coord_o (cx)
  );

  tlp_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_y (
    .pos_i   (in_i.pos_y),
    .size_i  (height_q),
    .coord_o (cy)
  );

  item_t item;
  assign item = '{op: in_i.operation, fid: in_i.finger_id, ts: in_i.timestamp};

  // Evaluate stage: long-press check and the event's own handling in one pass,
  // producing a bundle of up to four result words.
  logic    bundle_valid, bundle_ready;
  bundle_t bundle;

  tlp_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_item_i      (item),
    .in_x_i         (cx),
    .in_y_i         (cy),
    .lpt_i          (lpt_q),
    .slop_i         (slop_q),
    .bundle_ready_i (bundle_ready),
    .bundle_valid_o (bundle_valid),
    .bundle_o       (bundle)
  );

  // Result stage: hold the bundle and advance one word per accepted handshake.
  res_t res;
  logic res_last;

  tlp_drain u_drain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bundle_valid_i (bundle_valid),
    .bundle_ready_o (bundle_ready),
    .bundle_i       (bundle),
    .res_valid_o    (out_o.valid),
    .res_ready_i    (out_o.ready),
    .res_o          (res),
    .res_last_o     (res_last)
  );

  assign out_o.event_kind = res.kind;
  assign out_o.out_x      = res.x;
  assign out_o.out_y      = res.y;
  assign out_o.pressed    = res.pressed;
  assign out_o.last       = res_last;

endmodule
